// ===== src/sbc_pkg.sv =====
// sbc_pkg: shared constants and types for the sphere/box classifier.
// Holds the default coordinate width, pipeline depth and relation codes.
// No dependencies.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int COORD_BITS_DEF = 16;

  // register stages between the input and the result register
  localparam int PIPE_STAGES = 6;
  // clock edges from an accepted transaction to the edge that takes its result
  localparam int LATENCY = PIPE_STAGES + 1;

  typedef enum logic [1:0] {
    REL_INSIDE      = 2'd0,
    REL_INTERSECTED = 2'd1,
    REL_OUTSIDE     = 2'd2
  } relation_e;

endpackage

// ===== src/sphere_box_classify.sv =====
// sphere_box_classify: sphere versus axis-aligned box classifier, top level.
// Depends on sbc_pkg for the pipeline depth and relation codes.
`timescale 1ns / 1ps

// One transaction is taken on every clock edge at which start is high; busy
// is always low, as the datapath is a fixed pipeline of seven register stages
// (differences, squares, sums, enclosing-test operands, split partial products,
// product recombination, final compare). The relation of a transaction is shown
// on relation_o with done_o high for one cycle; results leave in acceptance
// order and the receiver cannot hold them off.
module sphere_box_classify #(
  parameter int COORD_BITS = sbc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] sphere_x_i,
  input  logic signed [COORD_BITS-1:0] sphere_y_i,
  input  logic signed [COORD_BITS-1:0] sphere_z_i,
  input  logic        [COORD_BITS-2:0] sphere_radius_i,
  input  logic signed [COORD_BITS-1:0] box_min_x_i,
  input  logic signed [COORD_BITS-1:0] box_min_y_i,
  input  logic signed [COORD_BITS-1:0] box_min_z_i,
  input  logic signed [COORD_BITS-1:0] box_max_x_i,
  input  logic signed [COORD_BITS-1:0] box_max_y_i,
  input  logic signed [COORD_BITS-1:0] box_max_z_i,
  input  logic                         box_empty_i,
  input  logic                         box_unbounded_i,
  output logic                         done_o,
  output logic        [1:0]            relation_o
);

  localparam int W   = COORD_BITS;
  localparam int NS  = sbc_pkg::PIPE_STAGES;
  localparam int CW  = W + 2;        // doubled centre offset, signed
  localparam int CA  = W + 1;        // its magnitude
  localparam int EA  = W;            // box extent magnitude
  localparam int DA  = W + 1;        // distance term magnitude
  localparam int RW  = W - 1;
  localparam int CSQ = 2 * CA;
  localparam int ESQ = 2 * EA;
  localparam int DSQ = 2 * DA;
  localparam int R2W = 2 * RW;
  localparam int SW  = CSQ + 2;
  localparam int LW  = ESQ + 2;
  localparam int DW  = DSQ + 3;
  localparam int PW  = LW + 1;       // 4r^2 + L and T
  localparam int H   = (PW + 1) / 2;
  localparam int TH  = PW - H;
  localparam int G   = (LW + 1) / 2;
  localparam int RH  = R2W - G;
  localparam int LH  = LW - G;
  localparam int MW  = 2 * PW;
  localparam int PRW = R2W + LW;

  // stage 1: offsets and magnitudes
  logic signed [W-1:0] c   [3];
  logic signed [W-1:0] mn  [3];
  logic signed [W-1:0] mx  [3];
  logic [CA-1:0] ca_d [3], ca_q [3];
  logic [EA-1:0] ea_d [3], ea_q [3];
  logic [DA-1:0] dl_d [3], dl_q [3];
  logic [DA-1:0] dh_d [3], dh_q [3];
  logic [RW-1:0] r_q;

  // stage 2: squares
  logic [CSQ-1:0] csq_d [3], csq_q [3];
  logic [ESQ-1:0] esq_d [3], esq_q [3];
  logic [DSQ-1:0] dlsq_d [3], dlsq_q [3];
  logic [DSQ-1:0] dhsq_d [3], dhsq_q [3];
  logic [R2W-1:0] r2_d, r2_q2;

  // stage 3: sums
  logic [SW-1:0]  s_d, s_q3;
  logic [LW-1:0]  l_d, l_q3;
  logic [DW-1:0]  dsum_d, dsum_q3;
  logic [R2W-1:0] r2_q3;

  // stage 4: enclosing-test operands
  logic [R2W+1:0] a4;
  logic [PW-1:0]  pos;
  logic [PW-1:0]  t_d, t_q4;
  logic           enc_d, enc_q4, enc_q5, enc_q6;
  logic           dlt_d, dlt_q4, dlt_q5, dlt_q6;
  logic [R2W-1:0] r2_q4;
  logic [LW-1:0]  l_q4;

  // stage 5: partial products
  logic [H-1:0]      tl;
  logic [TH-1:0]     th;
  logic [G-1:0]      rl, ll;
  logic [RH-1:0]     rh;
  logic [LH-1:0]     lh;
  logic [2*H-1:0]    pll_d, pll_q5;
  logic [PW-1:0]     plh_d, plh_q5;
  logic [2*TH-1:0]   phh_d, phh_q5;
  logic [2*G-1:0]    qll_d, qll_q5;
  logic [G+LH-1:0]   qlh_d, qlh_q5;
  logic [RH+G-1:0]   qhl_d, qhl_q5;
  logic [RH+LH-1:0]  qhh_d, qhh_q5;

  // stage 6: recombined products
  logic [MW-1:0]  tsq_d, tsq_q6;
  logic [PRW-1:0] prd_d, prd_q6;

  // control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] emp_q;
  logic [NS-1:0] unb_q;
  sbc_pkg::relation_e rel_d, rel_q;
  logic               done_q;

  assign busy = 1'b0;

  always_comb begin
    c[0]  = sphere_x_i;  c[1]  = sphere_y_i;  c[2]  = sphere_z_i;
    mn[0] = box_min_x_i; mn[1] = box_min_y_i; mn[2] = box_min_z_i;
    mx[0] = box_max_x_i; mx[1] = box_max_y_i; mx[2] = box_max_z_i;
  end

  always_comb begin
    logic signed [CW-1:0] cc;
    logic signed [W:0]    e;
    logic signed [W:0]    dm;
    logic signed [W:0]    dx;
    for (int i = 0; i < 3; i++) begin
      cc = (CW'(c[i]) <<< 1) - CW'(mn[i]) - CW'(mx[i]);
      ca_d[i] = cc[CW-1] ? CA'(-cc) : CA'(cc);
      e = (W+1)'(mx[i]) - (W+1)'(mn[i]);
      ea_d[i] = e[W] ? EA'(-e) : EA'(e);
      dm = (W+1)'(c[i]) - (W+1)'(mn[i]);
      dl_d[i] = dm[W] ? DA'(-dm) : '0;
      dx = (W+1)'(c[i]) - (W+1)'(mx[i]);
      dh_d[i] = (!dx[W] && dx != '0) ? DA'(dx) : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csq_d[i]  = CSQ'(ca_q[i]) * CSQ'(ca_q[i]);
      esq_d[i]  = ESQ'(ea_q[i]) * ESQ'(ea_q[i]);
      dlsq_d[i] = DSQ'(dl_q[i]) * DSQ'(dl_q[i]);
      dhsq_d[i] = DSQ'(dh_q[i]) * DSQ'(dh_q[i]);
    end
    r2_d = R2W'(r_q) * R2W'(r_q);
  end

  always_comb begin
    s_d    = SW'(csq_q[0]) + SW'(csq_q[1]) + SW'(csq_q[2]);
    l_d    = LW'(esq_q[0]) + LW'(esq_q[1]) + LW'(esq_q[2]);
    dsum_d = DW'(dlsq_q[0]) + DW'(dlsq_q[1]) + DW'(dlsq_q[2])
           + DW'(dhsq_q[0]) + DW'(dhsq_q[1]) + DW'(dhsq_q[2]);
  end

  always_comb begin
    a4    = {r2_q3, 2'b00};
    pos   = PW'(a4) + PW'(l_q3);
    enc_d = (PW'(a4) > PW'(l_q3)) && (SW'(pos) >= s_q3);
    t_d   = pos - PW'(s_q3);
    dlt_d = DW'(r2_q3) > dsum_q3;
  end

  always_comb begin
    tl    = t_q4[H-1:0];
    th    = t_q4[PW-1:H];
    pll_d = (2*H)'(tl) * (2*H)'(tl);
    plh_d = PW'(tl) * PW'(th);
    phh_d = (2*TH)'(th) * (2*TH)'(th);
    rl    = r2_q4[G-1:0];
    rh    = r2_q4[R2W-1:G];
    ll    = l_q4[G-1:0];
    lh    = l_q4[LW-1:G];
    qll_d = (2*G)'(rl) * (2*G)'(ll);
    qlh_d = (G+LH)'(rl) * (G+LH)'(lh);
    qhl_d = (RH+G)'(rh) * (RH+G)'(ll);
    qhh_d = (RH+LH)'(rh) * (RH+LH)'(lh);
  end

  always_comb begin
    tsq_d = MW'(pll_q5) + (MW'(plh_q5) << (H + 1)) + (MW'(phh_q5) << (2 * H));
    prd_d = PRW'(qll_q5) + ((PRW'(qlh_q5) + PRW'(qhl_q5)) << G)
          + (PRW'(qhh_q5) << (2 * G));
  end

  always_comb begin
    if (emp_q[NS-1]) begin
      rel_d = sbc_pkg::REL_INSIDE;
    end else if (unb_q[NS-1]) begin
      rel_d = sbc_pkg::REL_INTERSECTED;
    end else if (enc_q6 && (tsq_q6 >= (MW'(prd_q6) << 4))) begin
      rel_d = sbc_pkg::REL_INSIDE;
    end else if (dlt_q6) begin
      rel_d = sbc_pkg::REL_INTERSECTED;
    end else begin
      rel_d = sbc_pkg::REL_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q   <= ca_d;
    ea_q   <= ea_d;
    dl_q   <= dl_d;
    dh_q   <= dh_d;
    r_q    <= sphere_radius_i;
    csq_q  <= csq_d;
    esq_q  <= esq_d;
    dlsq_q <= dlsq_d;
    dhsq_q <= dhsq_d;
    r2_q2  <= r2_d;
    s_q3    <= s_d;
    l_q3    <= l_d;
    dsum_q3 <= dsum_d;
    r2_q3   <= r2_q2;
    t_q4   <= t_d;
    enc_q4 <= enc_d;
    dlt_q4 <= dlt_d;
    r2_q4  <= r2_q3;
    l_q4   <= l_q3;
    pll_q5 <= pll_d;
    plh_q5 <= plh_d;
    phh_q5 <= phh_d;
    qll_q5 <= qll_d;
    qlh_q5 <= qlh_d;
    qhl_q5 <= qhl_d;
    qhh_q5 <= qhh_d;
    enc_q5 <= enc_q4;
    dlt_q5 <= dlt_q4;
    tsq_q6 <= tsq_d;
    prd_q6 <= prd_d;
    enc_q6 <= enc_q5;
    dlt_q6 <= dlt_q5;
    emp_q  <= {emp_q[NS-2:0], box_empty_i};
    unb_q  <= {unb_q[NS-2:0], box_unbounded_i};
    rel_q  <= rel_d;
  end

  // advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[NS-2:0], start};
      done_q <= vld_q[NS-1];
    end
  end

  assign done_o     = done_q;
  assign relation_o = rel_q;

endmodule

// ===== src/sbc_checker.sv =====
// sbc_checker: port-level checks for sphere_box_classify, bound to the top level.
// Depends on sbc_pkg for the latency and relation codes.
`timescale 1ns / 1ps

module sbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       box_empty_i,
  input logic       box_unbounded_i,
  input logic       done_o,
  input logic [1:0] relation_o
);

  localparam int LAT = sbc_pkg::LATENCY;

  // every accepted transaction yields one result, a fixed time later
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##LAT !done_o)
    else $error("result without an accepted transaction");

  a_empty_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && box_empty_i) |-> ##LAT (relation_o == sbc_pkg::REL_INSIDE))
    else $error("null box not classified inside");

  a_unbounded_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !box_empty_i && box_unbounded_i)
      |-> ##LAT (relation_o == sbc_pkg::REL_INTERSECTED))
    else $error("infinite box not classified intersected");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (relation_o == sbc_pkg::REL_INSIDE
             || relation_o == sbc_pkg::REL_INTERSECTED
             || relation_o == sbc_pkg::REL_OUTSIDE))
    else $error("undefined relation code");

endmodule

bind sphere_box_classify sbc_checker u_sbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .box_empty_i     (box_empty_i),
  .box_unbounded_i (box_unbounded_i),
  .done_o          (done_o),
  .relation_o      (relation_o)
);

// ===== bench/sbc_relation_checker.sv =====
// sbc_relation_checker: watches the query and result channels of sphere_box_classify,
// predicts each relation and compares it with the one the block returns.
// Depends on sbc_pkg for the coordinate width and the relation codes.
`timescale 1ns / 1ps

module sbc_relation_checker #(
  parameter int CB = sbc_pkg::COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  logic signed [CB-1:0] sphere_x_i,
  input  logic signed [CB-1:0] sphere_y_i,
  input  logic signed [CB-1:0] sphere_z_i,
  input  logic        [CB-2:0] sphere_radius_i,
  input  logic signed [CB-1:0] box_min_x_i,
  input  logic signed [CB-1:0] box_min_y_i,
  input  logic signed [CB-1:0] box_min_z_i,
  input  logic signed [CB-1:0] box_max_x_i,
  input  logic signed [CB-1:0] box_max_y_i,
  input  logic signed [CB-1:0] box_max_z_i,
  input  logic                 box_empty_i,
  input  logic                 box_unbounded_i,
  input  logic                 done_i,
  input  logic        [1:0]    relation_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   inside_o,
  output int                   intersected_o,
  output int                   outside_o
);

  sbc_pkg::relation_e relation_due_q[$];
  sbc_pkg::relation_e due;

  function automatic sbc_pkg::relation_e predict_relation(
    input logic signed [CB-1:0] cx, cy, cz,
    input logic        [CB-2:0] rad,
    input logic signed [CB-1:0] lox, loy, loz, hix, hiy, hiz,
    input logic                 empty, unbounded
  );
    longint ctr[3], lo[3], hi[3];
    longint r2, sum_c, sum_l, gap_sq, pos, dc, dm, dx;
    logic [127:0] t_w, a_w, b_w;
    int i;
    if (empty) return sbc_pkg::REL_INSIDE;
    if (unbounded) return sbc_pkg::REL_INTERSECTED;
    ctr[0] = cx;  ctr[1] = cy;  ctr[2] = cz;
    lo[0]  = lox; lo[1]  = loy; lo[2]  = loz;
    hi[0]  = hix; hi[1]  = hiy; hi[2]  = hiz;
    r2 = longint'(rad) * longint'(rad);
    sum_c = 0;
    sum_l = 0;
    gap_sq = 0;
    for (i = 0; i < 3; i++) begin
      dc = 2 * ctr[i] - lo[i] - hi[i];
      sum_c += dc * dc;
      dc = hi[i] - lo[i];
      sum_l += dc * dc;
    end
    // enclosing test on doubled quantities, squared to avoid the root
    if (4 * r2 > sum_l) begin
      pos = 4 * r2 + sum_l;
      if (pos >= sum_c) begin
        t_w = pos - sum_c;
        a_w = 4 * r2;
        b_w = 4 * sum_l;
        if (t_w * t_w >= a_w * b_w) return sbc_pkg::REL_INSIDE;
      end
    end
    for (i = 0; i < 3; i++) begin
      dm = ctr[i] - lo[i];
      dx = ctr[i] - hi[i];
      if (dm < 0) gap_sq += dm * dm;
      if (dx > 0) gap_sq += dx * dx;
    end
    return (gap_sq < r2) ? sbc_pkg::REL_INTERSECTED : sbc_pkg::REL_OUTSIDE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relation_due_q.delete();
      errors_o      = 0;
      pending_o     = 0;
      inside_o      = 0;
      intersected_o = 0;
      outside_o     = 0;
    end else begin
      if (done_i) begin
        if (relation_due_q.size() == 0) begin
          errors_o++;
          $display("%0t: relation %0d returned with no transaction outstanding",
                   $time, relation_i);
        end else begin
          due = relation_due_q.pop_front();
          if (relation_i !== due) begin
            errors_o++;
            $display("%0t: relation mismatch: expected %s (%0d), actual %0d",
                     $time, due.name(), due, relation_i);
          end
          case (due)
            sbc_pkg::REL_INSIDE:      inside_o++;
            sbc_pkg::REL_INTERSECTED: intersected_o++;
            default:                  outside_o++;
          endcase
        end
      end
      if (start && !busy) begin
        relation_due_q.push_back(predict_relation(
          sphere_x_i, sphere_y_i, sphere_z_i, sphere_radius_i,
          box_min_x_i, box_min_y_i, box_min_z_i,
          box_max_x_i, box_max_y_i, box_max_z_i,
          box_empty_i, box_unbounded_i));
      end
      pending_o = relation_due_q.size();
    end
  end

endmodule

// ===== bench/tb_sphere_box_classify.sv =====
// tb_sphere_box_classify: drives directed and random sphere/box queries into
// sphere_box_classify with random gaps and reports the verdict.
// Depends on sbc_pkg and on sbc_relation_checker for prediction and comparison.
`timescale 1ns / 1ps

module tb_sphere_box_classify;

  localparam int CB      = sbc_pkg::COORD_BITS_DEF;
  localparam int QUERIES = 1000;

  typedef struct {
    logic signed [CB-1:0] cx, cy, cz;
    logic        [CB-2:0] rad;
    logic signed [CB-1:0] lox, loy, loz, hix, hiy, hiz;
    logic                 empty, unbounded;
  } query_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic signed [CB-1:0] sphere_x_i      = '0;
  logic signed [CB-1:0] sphere_y_i      = '0;
  logic signed [CB-1:0] sphere_z_i      = '0;
  logic        [CB-2:0] sphere_radius_i = '0;
  logic signed [CB-1:0] box_min_x_i     = '0;
  logic signed [CB-1:0] box_min_y_i     = '0;
  logic signed [CB-1:0] box_min_z_i     = '0;
  logic signed [CB-1:0] box_max_x_i     = '0;
  logic signed [CB-1:0] box_max_y_i     = '0;
  logic signed [CB-1:0] box_max_z_i     = '0;
  logic                 box_empty_i     = 1'b0;
  logic                 box_unbounded_i = 1'b0;
  logic                 done_o;
  logic        [1:0]    relation_o;

  int mismatches, awaiting, n_inside, n_intersected, n_outside;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sphere_box_classify #(.COORD_BITS(CB)) i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .sphere_x_i, .sphere_y_i, .sphere_z_i, .sphere_radius_i,
    .box_min_x_i, .box_min_y_i, .box_min_z_i,
    .box_max_x_i, .box_max_y_i, .box_max_z_i,
    .box_empty_i, .box_unbounded_i,
    .done_o, .relation_o
  );

  sbc_relation_checker #(.CB(CB)) i_checker (
    .clk_i, .rst_ni, .start, .busy,
    .sphere_x_i, .sphere_y_i, .sphere_z_i, .sphere_radius_i,
    .box_min_x_i, .box_min_y_i, .box_min_z_i,
    .box_max_x_i, .box_max_y_i, .box_max_z_i,
    .box_empty_i, .box_unbounded_i,
    .done_i        (done_o),
    .relation_i    (relation_o),
    .errors_o      (mismatches),
    .pending_o     (awaiting),
    .inside_o      (n_inside),
    .intersected_o (n_intersected),
    .outside_o     (n_outside)
  );

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic query_t make_query(input int cx, cy, cz, rad,
                                        input int lox, loy, loz, hix, hiy, hiz,
                                        input bit empty, unbounded);
    query_t q;
    q.cx  = cx[CB-1:0];  q.cy  = cy[CB-1:0];  q.cz  = cz[CB-1:0];
    q.rad = rad[CB-2:0];
    q.lox = lox[CB-1:0]; q.loy = loy[CB-1:0]; q.loz = loz[CB-1:0];
    q.hix = hix[CB-1:0]; q.hiy = hiy[CB-1:0]; q.hiz = hiz[CB-1:0];
    q.empty     = empty;
    q.unbounded = unbounded;
    return q;
  endfunction

  // mostly boxes with a nearby sphere, the rest fully random words
  function automatic query_t random_query();
    query_t q;
    int     kind, emax, base, tmp, dm, r, i;
    int     lo_a[3], hi_a[3], c_a[3];
    longint gap_sq;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      q = make_query($urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(),
                     (kind < 8) ? $urandom_range(0, 1) : 0,
                     (kind < 8) ? $urandom_range(0, 1) : 0);
      return q;
    end
    emax   = 16 << (3 * $urandom_range(0, 3));
    gap_sq = 0;
    for (i = 0; i < 3; i++) begin
      base    = int'($urandom_range(0, 16000)) - 8000;
      lo_a[i] = base - int'($urandom_range(0, emax));
      hi_a[i] = base + int'($urandom_range(0, emax));
      if ($urandom_range(0, 15) == 0) begin
        tmp     = lo_a[i];
        lo_a[i] = hi_a[i];
        hi_a[i] = tmp;
      end
      c_a[i] = base + int'($urandom_range(0, 4 * emax)) - 2 * emax;
      dm = c_a[i] - lo_a[i];
      if (dm < 0) gap_sq += longint'(dm) * dm;
      dm = c_a[i] - hi_a[i];
      if (dm > 0) gap_sq += longint'(dm) * dm;
    end
    case ($urandom_range(0, 3))
      0:       r = $urandom_range(0, 3 * emax);
      1:       r = int'($sqrt(real'(gap_sq))) + int'($urandom_range(0, 2)) - 1;
      2:       r = $urandom_range(0, 32767);
      default: r = $urandom_range(0, 8);
    endcase
    if (r < 0) r = 0;
    if (r > 32767) r = 32767;
    q = make_query(c_a[0], c_a[1], c_a[2], r, lo_a[0], lo_a[1], lo_a[2],
                   hi_a[0], hi_a[1], hi_a[2], 0, 0);
    if ($urandom_range(0, 31) == 0) begin
      q.empty     = $urandom_range(0, 1);
      q.unbounded = $urandom_range(0, 1);
    end
    return q;
  endfunction

  task automatic send_query(input query_t q, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    sphere_x_i      <= q.cx;
    sphere_y_i      <= q.cy;
    sphere_z_i      <= q.cz;
    sphere_radius_i <= q.rad;
    box_min_x_i     <= q.lox;
    box_min_y_i     <= q.loy;
    box_min_z_i     <= q.loz;
    box_max_x_i     <= q.hix;
    box_max_y_i     <= q.hiy;
    box_max_z_i     <= q.hiz;
    box_empty_i     <= q.empty;
    box_unbounded_i <= q.unbounded;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    query_t directed_q[$];
    int     gap_cap, n;
    directed_q.push_back(make_query(0, 0, 0, 5, -1, -1, -1, 1, 1, 1, 1, 0));
    directed_q.push_back(make_query(0, 0, 0, 5, -1, -1, -1, 1, 1, 1, 1, 1));
    directed_q.push_back(make_query(0, 0, 0, 5, -1, -1, -1, 1, 1, 1, 0, 1));
    directed_q.push_back(make_query(0, 0, 0, 0, -10, -10, -10, 10, 10, 10, 0, 0));
    directed_q.push_back(make_query(0, 0, 0, 3, -10, -10, -10, 10, 10, 10, 0, 0));
    directed_q.push_back(make_query(0, 0, 0, 100, -10, -10, -10, 10, 10, 10, 0, 0));
    directed_q.push_back(make_query(1000, 1000, 1000, 10, -10, -10, -10, 10, 10, 10, 0, 0));
    directed_q.push_back(make_query(-32768, -32768, -32768, 32767, -32768, -32768, -32768,
                                    -32768, -32768, -32768, 0, 0));
    directed_q.push_back(make_query(32767, 32767, 32767, 32767, -32768, -32768, -32768,
                                    32767, 32767, 32767, 0, 0));
    directed_q.push_back(make_query(-32768, 32767, -32768, 32767, 32767, 32767, 32767,
                                    -32768, -32768, -32768, 0, 0));
    directed_q.push_back(make_query(0, 0, 0, 10, 10, 0, 0, 20, 5, 5, 0, 0));
    directed_q.push_back(make_query(0, 0, 0, 11, 10, 0, 0, 20, 5, 5, 0, 0));
    directed_q.push_back(make_query(3, 4, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_query(3, 4, 0, 4, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_query(1, 0, 0, 1, 0, 0, 0, 2, 0, 0, 0, 0));
    directed_q.push_back(make_query(0, 0, 0, 5, 3, 0, 0, -3, 0, 0, 0, 0));
    directed_q.push_back(make_query(7, 7, 7, 0, 7, 7, 7, 7, 7, 7, 0, 0));
    directed_q.push_back(make_query(32767, -32768, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 1, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[k]) send_query(directed_q[k], $urandom_range(0, 16));

    gap_cap = 16;
    for (n = 0; n < QUERIES; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_cap = 0;
          1:       gap_cap = 4;
          default: gap_cap = 16;
        endcase
      end
      send_query(random_query(), $urandom_range(0, gap_cap));
    end
    start <= 1'b0;

    do @(negedge clk_i); while (awaiting != 0);
    repeat (sbc_pkg::LATENCY + 2) @(posedge clk_i);

    $display("Classified %0d directed and %0d random queries with random gaps.",
             directed_q.size(), QUERIES);
    $display("Relations seen: %0d inside, %0d intersected, %0d outside; %0d mismatches.",
             n_inside, n_intersected, n_outside, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
